@@ hw/rtl/text_encoding_detector_unit_macros.svh @@
// assertion macros for the checker file
`ifndef TEXT_ENCODING_DETECTOR_UNIT_MACROS_SVH
`define TEXT_ENCODING_DETECTOR_UNIT_MACROS_SVH

// plain property, clocked on clk_i and muted during reset
`define TED_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ted checker: property violated");

// antecedent implies consequent in the next cycle
`define TED_ASSERT_NEXT(lbl, ante, cons) \
  `TED_ASSERT(lbl, (ante) |=> (cons))

`endif

@@ hw/rtl/ted_pkg.sv @@
package ted_pkg;

  typedef enum logic [2:0] {
    ENC_UTF16_LE   = 3'd0,
    ENC_UTF16_BE   = 3'd1,
    ENC_UTF8_BOM   = 3'd2,
    ENC_ASCII      = 3'd3,
    ENC_UTF8_NOBOM = 3'd4,
    ENC_OTHER      = 3'd5
  } ted_enc_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } ted_item_t;

  localparam logic [15:0] BomUtf16Le   = 16'hFFFE;
  localparam logic [15:0] BomUtf16Be   = 16'hFEFF;
  localparam logic [15:0] BomUtf8Head  = 16'hEFBB;
  localparam logic [7:0]  BomUtf8Tail  = 8'hBF;

  localparam logic [1:0] PosFirst  = 2'd0;
  localparam logic [1:0] PosSecond = 2'd1;
  localparam logic [1:0] PosThird  = 2'd2;
  localparam logic [1:0] PosLater  = 2'd3;

endpackage

@@ hw/rtl/ted_in_reg.sv @@
module ted_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ted_pkg::ted_item_t  in_item_i,
  input  logic                slot_free_i,
  output logic                go_o,
  output ted_pkg::ted_item_t  item_o
);
  import ted_pkg::*;

  logic      valid_q, valid_d;
  ted_item_t item_q;

  // a non-last byte only updates state, so only a last byte needs the result slot
  assign go_o       = valid_q && (!item_q.is_last || slot_free_i);
  assign in_ready_o = !valid_q || go_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

@@ hw/rtl/ted_scan.sv @@
module ted_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  ted_pkg::ted_item_t  item_i,
  output ted_pkg::ted_enc_e   enc_o
);
  import ted_pkg::*;

  logic [2:0]  pend_q, pend_d;
  logic        ascii_q, ascii_d;
  logic        err_q, err_d;
  logic [1:0]  pos_q, pos_d;
  logic [15:0] lead_q, lead_d;
  logic [7:0]  b;

  assign b = item_i.data_byte;

  always_comb begin
    lead_d  = lead_q;
    pend_d  = pend_q;
    ascii_d = ascii_q;
    err_d   = err_q;
    pos_d   = pos_q;

    case (pos_q)
      PosFirst:  lead_d = {b, 8'h00};
      PosSecond: lead_d = {lead_q[15:8], b};
      PosThird: begin
        if (lead_q == BomUtf8Head && b != BomUtf8Tail) begin
          lead_d = 16'h0000;
        end
      end
      default: lead_d = lead_q;
    endcase

    if (b[7]) begin
      ascii_d = 1'b0;
    end

    if (pend_q == 3'd0) begin
      if (b[7]) begin
        // fe and ff fall in the five-byte range
        if (b inside {8'hFC, 8'hFD}) begin
          pend_d = 3'd5;
        end else if (b inside {[8'hF8:8'hFF]}) begin
          pend_d = 3'd4;
        end else if (b inside {[8'hF0:8'hF7]}) begin
          pend_d = 3'd3;
        end else if (b inside {[8'hE0:8'hEF]}) begin
          pend_d = 3'd2;
        end else if (b inside {[8'hC0:8'hDF]}) begin
          pend_d = 3'd1;
        end else begin
          err_d = 1'b1;
        end
      end
    end else begin
      if (b[7:6] != 2'b10) begin
        err_d = 1'b1;
      end
      pend_d = pend_q - 3'd1;
    end

    if (pos_q != PosLater) begin
      pos_d = pos_q + 2'd1;
    end
  end

  always_comb begin
    if (pos_q != PosFirst && lead_d == BomUtf16Le) begin
      enc_o = ENC_UTF16_LE;
    end else if (pos_q != PosFirst && lead_d == BomUtf16Be) begin
      enc_o = ENC_UTF16_BE;
    end else if ((pos_q == PosThird || pos_q == PosLater) && lead_d == BomUtf8Head) begin
      enc_o = ENC_UTF8_BOM;
    end else if (err_d || pend_d != 3'd0) begin
      enc_o = ENC_OTHER;
    end else if (ascii_d) begin
      enc_o = ENC_ASCII;
    end else begin
      enc_o = ENC_UTF8_NOBOM;
    end
  end

  // the last byte closes the buffer and the next byte starts afresh
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 3'd0;
      ascii_q <= 1'b1;
      err_q   <= 1'b0;
      pos_q   <= PosFirst;
      lead_q  <= 16'h0000;
    end else if (go_i) begin
      if (item_i.is_last) begin
        pend_q  <= 3'd0;
        ascii_q <= 1'b1;
        err_q   <= 1'b0;
        pos_q   <= PosFirst;
        lead_q  <= 16'h0000;
      end else begin
        pend_q  <= pend_d;
        ascii_q <= ascii_d;
        err_q   <= err_d;
        pos_q   <= pos_d;
        lead_q  <= lead_d;
      end
    end
  end

endmodule

@@ hw/rtl/ted_out_reg.sv @@
module ted_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  ted_pkg::ted_enc_e  enc_i,
  output logic               slot_free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         out_enc_o
);
  import ted_pkg::*;

  logic       valid_q, valid_d;
  logic [2:0] enc_q;

  assign slot_free_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_enc_o   = enc_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      enc_q <= 3'(enc_i);
    end
  end

endmodule

@@ hw/rtl/text_encoding_detector_unit.sv @@
// Classifies a text buffer streamed in one byte per transfer, tlast on its final byte,
// and returns one encoding code per buffer (0 utf-16 le, 1 utf-16 be, 2 utf-8 with
// mark, 3 ascii, 4 utf-8 without mark, 5 other). A byte is taken every cycle unless a
// last byte waits for the result slot. The input register captures the last byte at
// its transfer and the result register takes the code from it once the slot is free,
// and offers it. The result register lets the next buffer stream in while a code
// waits to be taken; only a second last byte stalls until the slot frees.
module text_encoding_detector_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] data_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o   // [2:0] encoding, [7:3] zero
);
  import ted_pkg::*;

  ted_item_t in_item;
  ted_item_t item;
  ted_enc_e  enc;
  logic      go;
  logic      slot_free;
  logic      last_go;
  logic [2:0] out_enc;

  assign in_item.data_byte = s_axis_tdata_i;
  assign in_item.is_last   = s_axis_tlast_i;
  assign last_go           = go && item.is_last;

  ted_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (in_item),
    .slot_free_i (slot_free),
    .go_o        (go),
    .item_o      (item)
  );

  ted_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .item_i (item),
    .enc_o  (enc)
  );

  ted_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (last_go),
    .enc_i       (enc),
    .slot_free_o (slot_free),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_enc_o   (out_enc)
  );

  assign m_axis_tdata_o = {5'b00000, out_enc};

endmodule

@@ hw/rtl/ted_checker.sv @@
`include "text_encoding_detector_unit_macros.svh"

module ted_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       s_axis_tlast_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  logic in_last_xfer;
  logic code_ok;

  assign in_last_xfer = s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i;
  assign code_ok      = m_axis_tdata_o[7:3] == 5'd0 && m_axis_tdata_o[2:0] != 3'd6
                        && m_axis_tdata_o[2:0] != 3'd7;

  // a waiting code holds until its transfer
  `TED_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // only the six defined codes leave the block
  `TED_ASSERT(a_code_range, !m_axis_tvalid_o || code_ok)

  // a fresh code is offered only after a last-byte transfer has passed the input and result registers
  `TED_ASSERT(a_code_after_last, $rose(m_axis_tvalid_o) |-> $past(in_last_xfer, 2))

endmodule

bind text_encoding_detector_unit ted_checker u_ted_checker (.*);

@@ dv/text_encoding_detector_unit_tb.sv @@
module text_encoding_detector_unit_tb;
  import ted_pkg::*;

  localparam int unsigned ByteTarget  = 1500;
  localparam int unsigned TailStart   = 1300;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned SettleTicks = 8;

  typedef struct {
    logic [7:0] data_byte;
    logic       is_last;
    bit         typed;
    ted_enc_e   want;
  } dir_row_t;

  // scan state of the buffer in flight
  typedef struct {
    logic [2:0]  cont_due;
    logic        only_ascii;
    logic        bad_seq;
    logic [1:0]  seen;
    logic [15:0] head;
  } scan_state_t;

  localparam scan_state_t ScanClear = '{3'd0, 1'b1, 1'b0, PosFirst, 16'h0000};

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       rx_ready = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;

  scan_state_t scan = ScanClear;
  ted_enc_e    enc_expected [$];
  logic [7:0]  text_buf [$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned buffers_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned code_seen [6];
  bit          hold_req = 1'b0;
  bit          tail_run = 1'b0;
  bit          burst_mode = 1'b0;

  dir_row_t dir_rows [24] = '{
    '{8'h41, 1'b1, 1'b1, ENC_ASCII},
    '{8'h00, 1'b1, 1'b1, ENC_ASCII},
    '{8'hFF, 1'b0, 1'b0, ENC_OTHER},
    '{8'hFE, 1'b1, 1'b1, ENC_UTF16_LE},
    '{8'hFE, 1'b0, 1'b0, ENC_OTHER},
    '{8'hFF, 1'b1, 1'b1, ENC_UTF16_BE},
    '{8'hEF, 1'b0, 1'b0, ENC_OTHER},
    '{8'hBB, 1'b0, 1'b0, ENC_OTHER},
    '{8'hBF, 1'b1, 1'b1, ENC_UTF8_BOM},
    // broken utf-8 mark, falls through to the utf-8 scan
    '{8'hEF, 1'b0, 1'b0, ENC_OTHER},
    '{8'hBB, 1'b0, 1'b0, ENC_OTHER},
    '{8'h41, 1'b1, 1'b0, ENC_OTHER},
    // lone five-byte lead, cut off
    '{8'hFF, 1'b1, 1'b1, ENC_OTHER},
    // too short for the three-byte mark
    '{8'hEF, 1'b0, 1'b0, ENC_OTHER},
    '{8'hBB, 1'b1, 1'b0, ENC_OTHER},
    '{8'hC3, 1'b0, 1'b0, ENC_OTHER},
    '{8'hA9, 1'b1, 1'b0, ENC_OTHER},
    // stray continuation
    '{8'h80, 1'b1, 1'b1, ENC_OTHER},
    '{8'hFC, 1'b0, 1'b0, ENC_OTHER},
    '{8'h80, 1'b0, 1'b0, ENC_OTHER},
    '{8'hBF, 1'b0, 1'b0, ENC_OTHER},
    '{8'h80, 1'b0, 1'b0, ENC_OTHER},
    '{8'hBF, 1'b0, 1'b0, ENC_OTHER},
    '{8'h80, 1'b1, 1'b0, ENC_OTHER}
  };

  text_encoding_detector_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),  // [7:0] data_byte
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (rx_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)  // [2:0] encoding, [7:3] zero
  );

  always #6 clk_i = ~clk_i;

  // advances the scan by one byte; gives a code on the buffer's last byte
  function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                   output ted_enc_e code);
    logic [1:0] pos;
    pos = scan.seen;
    code = ENC_OTHER;
    case (pos)
      PosFirst: begin
        scan.head = {b, 8'h00};
      end
      PosSecond: begin
        scan.head[7:0] = b;
      end
      PosThird: begin
        if (scan.head == BomUtf8Head && b != BomUtf8Tail) scan.head = 16'h0000;
      end
      default: ;
    endcase
    if (b[7]) scan.only_ascii = 1'b0;
    if (scan.cont_due == 3'd0) begin
      if (b[7]) begin
        if (b == 8'hFC || b == 8'hFD) scan.cont_due = 3'd5;
        else if (b >= 8'hF8) scan.cont_due = 3'd4;
        else if (b >= 8'hF0) scan.cont_due = 3'd3;
        else if (b >= 8'hE0) scan.cont_due = 3'd2;
        else if (b >= 8'hC0) scan.cont_due = 3'd1;
        else scan.bad_seq = 1'b1;
      end
    end else begin
      if (b[7:6] != 2'b10) scan.bad_seq = 1'b1;
      scan.cont_due = scan.cont_due - 3'd1;
    end
    if (scan.seen != PosLater) scan.seen = scan.seen + 2'd1;
    if (!last) return 1'b0;
    if (pos != PosFirst && scan.head == BomUtf16Le) code = ENC_UTF16_LE;
    else if (pos != PosFirst && scan.head == BomUtf16Be) code = ENC_UTF16_BE;
    else if (pos >= PosThird && scan.head == BomUtf8Head) code = ENC_UTF8_BOM;
    else if (scan.bad_seq || scan.cont_due != 3'd0) code = ENC_OTHER;
    else if (scan.only_ascii) code = ENC_ASCII;
    else code = ENC_UTF8_NOBOM;
    scan = ScanClear;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0d] encoding check: %s (got %0d, want %0d)", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last, input bit typed,
                           input ted_enc_e want);
    ted_enc_e code;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_sent++;
    if (scan_byte(b, last, code)) begin
      enc_expected.push_back(typed ? want : code);
      code_seen[code]++;
      buffers_sent++;
    end
    if (!tail_run && !burst_mode && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // one character of old-style utf-8, 1 to 6 bytes
  task automatic add_char(input int unsigned len);
    int unsigned pick;
    pick = $urandom_range(0, 5);
    case (len)
      1: text_buf.push_back(8'($urandom_range(0, 127)));
      2: text_buf.push_back(8'hC0 | 8'($urandom_range(0, 31)));
      3: text_buf.push_back(8'hE0 | 8'($urandom_range(0, 15)));
      4: text_buf.push_back(8'hF0 | 8'($urandom_range(0, 7)));
      5: text_buf.push_back(pick < 4 ? 8'hF8 + 8'(pick) : (pick == 4 ? 8'hFE : 8'hFF));
      default: text_buf.push_back(8'hFC | 8'($urandom_range(0, 1)));
    endcase
    repeat (len - 1) text_buf.push_back(8'h80 | 8'($urandom_range(0, 63)));
  endtask

  task automatic add_text(input int unsigned chars);
    repeat (chars) add_char($urandom_range(0, 1) ? 1 : $urandom_range(2, 6));
  endtask

  task automatic make_buffer();
    int unsigned kind;
    int unsigned mark;
    kind = $urandom_range(0, 19);
    text_buf.delete();
    if (kind <= 2) begin
      mark = $urandom_range(0, 2);
      if (mark == 0) begin
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'hFE);
      end else if (mark == 1) begin
        text_buf.push_back(8'hFE);
        text_buf.push_back(8'hFF);
      end else begin
        text_buf.push_back(8'hEF);
        text_buf.push_back(8'hBB);
        text_buf.push_back(8'hBF);
      end
      add_text($urandom_range(0, 3));
    end else if (kind <= 11) begin
      add_text($urandom_range(1, 5));
    end else if (kind <= 13) begin
      repeat ($urandom_range(1, 8)) add_char(1);
    end else if (kind <= 16) begin
      // well-formed text with one fault: truncated or one byte overwritten
      add_text($urandom_range(1, 5));
      if (text_buf.size() > 1 && $urandom_range(0, 1)) void'(text_buf.pop_back());
      else text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
    end else begin
      repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_buffer();
    foreach (text_buf[i]) push_byte(text_buf[i], i == text_buf.size() - 1, 1'b0, ENC_OTHER);
  endtask

  // result side readiness, with random stalls and one long hold-off
  initial begin
    int unsigned rx_gap;
    int unsigned rx_hold;
    rx_gap = 0;
    rx_hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        rx_hold = HoldCycles;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        rx_ready <= 1'b0;
      end else if (tail_run) begin
        rx_ready <= 1'b1;
      end else if (rx_gap != 0) begin
        rx_gap--;
        rx_ready <= 1'b0;
      end else begin
        rx_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 9);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && rx_ready) begin
      if (enc_expected.size() == 0) begin
        report_mismatch("result with nothing expected", m_axis_tdata_o, -1);
      end else begin
        if (m_axis_tdata_o[2:0] != enc_expected[0])
          report_mismatch("wrong encoding", m_axis_tdata_o[2:0], enc_expected[0]);
        if (m_axis_tdata_o[7:3] != 5'd0)
          report_mismatch("padding bits set", m_axis_tdata_o[7:3], 0);
        void'(enc_expected.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               enc_expected.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    bit held;
    bit paused;
    held = 1'b0;
    paused = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      push_byte(dir_rows[i].data_byte, dir_rows[i].is_last, dir_rows[i].typed,
                dir_rows[i].want);

    while (bytes_sent < ByteTarget) begin
      if (!held && bytes_sent >= 400) begin
        // short buffers back to back while results are held back
        held = 1'b1;
        hold_req = 1'b1;
        burst_mode = 1'b1;
        repeat (30) begin
          text_buf.delete();
          repeat ($urandom_range(1, 3)) add_char(1);
          send_buffer();
        end
        burst_mode = 1'b0;
      end
      if (!paused && bytes_sent >= 900) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        wait (enc_expected.size() == 0);
        @(posedge clk_i);
      end
      if (bytes_sent >= TailStart) tail_run = 1'b1;
      make_buffer();
      send_buffer();
    end

    s_tvalid <= 1'b0;
    wait (enc_expected.size() == 0);
    repeat (SettleTicks) @(posedge clk_i);

    $display("covered %0d buffers in %0d bytes: marks, ascii, valid and broken utf-8",
             buffers_sent, bytes_sent);
    $display("codes: le %0d, be %0d, utf8 mark %0d, ascii %0d, utf8 %0d, other %0d",
             code_seen[0], code_seen[1], code_seen[2], code_seen[3], code_seen[4],
             code_seen[5]);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
